### hdl/fixed_point_matrix3_inverse_core_defines.svh
// Assertion macros shared by the matrix inverse core.
`ifndef FIXED_POINT_MATRIX3_INVERSE_CORE_DEFINES_SVH
`define FIXED_POINT_MATRIX3_INVERSE_CORE_DEFINES_SVH

// The consequent must hold whenever the antecedent holds.
`define FPM3I_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The condition must never be seen at a clock edge.
`define FPM3I_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

### hdl/fpm3i_pkg.sv
package fpm3i_pkg;

  localparam int unsigned Lanes      = 9;
  localparam int unsigned DetTerms   = 6;
  localparam int unsigned DivSteps   = 64;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = 2;

  // Element indexes of the Sarrus terms; the first three are added, the rest subtracted.
  localparam logic [3:0] DetA [DetTerms] = '{4'd0, 4'd1, 4'd2, 4'd2, 4'd0, 4'd1};
  localparam logic [3:0] DetB [DetTerms] = '{4'd4, 4'd5, 4'd3, 4'd4, 4'd5, 4'd3};
  localparam logic [3:0] DetC [DetTerms] = '{4'd8, 4'd6, 4'd7, 4'd6, 4'd7, 4'd8};

  // Adjugate element k is m[AdjA]*m[AdjB] - m[AdjC]*m[AdjD].
  localparam logic [3:0] AdjA [Lanes] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
  localparam logic [3:0] AdjB [Lanes] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
  localparam logic [3:0] AdjC [Lanes] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
  localparam logic [3:0] AdjD [Lanes] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

  typedef struct packed {
    logic signed [31:0] in_r0c0;
    logic signed [31:0] in_r0c1;
    logic signed [31:0] in_r0c2;
    logic signed [31:0] in_r1c0;
    logic signed [31:0] in_r1c1;
    logic signed [31:0] in_r1c2;
    logic signed [31:0] in_r2c0;
    logic signed [31:0] in_r2c1;
    logic signed [31:0] in_r2c2;
  } in_t;

  typedef struct packed {
    logic signed [31:0] inv_r0c0;
    logic signed [31:0] inv_r0c1;
    logic signed [31:0] inv_r0c2;
    logic signed [31:0] inv_r1c0;
    logic signed [31:0] inv_r1c1;
    logic signed [31:0] inv_r1c2;
    logic signed [31:0] inv_r2c0;
    logic signed [31:0] inv_r2c1;
    logic signed [31:0] inv_r2c2;
    logic signed [31:0] det_value;
    logic               invertible;
  } out_t;

  // Work handed from the front to the divider.
  typedef struct packed {
    logic [Lanes-1:0][63:0] adj;
    logic [31:0]            det;
  } mid_t;

  // One divider stage: partial remainders, shifting dividends and quotients.
  typedef struct packed {
    logic [Lanes-1:0][31:0] rem;
    logic [Lanes-1:0][63:0] dvd;
    logic [Lanes-1:0]       neg;
    logic [31:0]            dmag;
    logic [31:0]            det;
  } div_t;

endpackage

### hdl/fpm3i_front.sv
module fpm3i_front #(
  parameter int unsigned FractionBits = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  fpm3i_pkg::in_t   in_data_i,
  output logic             mid_valid_o,
  input  logic             mid_ready_i,
  output fpm3i_pkg::mid_t  mid_data_o
);

  localparam int unsigned Lanes = fpm3i_pkg::Lanes;
  localparam int unsigned Terms = fpm3i_pkg::DetTerms;

  logic               en;
  logic signed [31:0] m [Lanes];

  logic               v1_q, v2_q, v3_q, v4_q, v5_q;
  logic signed [63:0] dp_q  [Terms];
  logic signed [31:0] c_q   [Terms];
  logic signed [63:0] xa_q  [Lanes];
  logic signed [63:0] xc_q  [Lanes];
  logic signed [63:0] lo_q  [Terms];
  logic [31:0]        hi_q  [Terms];
  logic signed [63:0] adj2_q [Lanes];
  logic signed [63:0] t_q   [Terms];
  logic signed [63:0] adj3_q [Lanes];
  logic signed [63:0] pos_q, neg_q;
  logic signed [63:0] adj4_q [Lanes];
  fpm3i_pkg::mid_t    mid_q;

  assign m[0] = in_data_i.in_r0c0;
  assign m[1] = in_data_i.in_r0c1;
  assign m[2] = in_data_i.in_r0c2;
  assign m[3] = in_data_i.in_r1c0;
  assign m[4] = in_data_i.in_r1c1;
  assign m[5] = in_data_i.in_r1c2;
  assign m[6] = in_data_i.in_r2c0;
  assign m[7] = in_data_i.in_r2c1;
  assign m[8] = in_data_i.in_r2c2;

  assign en          = !v5_q || mid_ready_i;
  assign in_ready_o  = en;
  assign mid_valid_o = v5_q;
  assign mid_data_o  = mid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Stage 1: exact pair products for the determinant and the adjugate.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < Terms; k++) begin
        dp_q[k] <= 64'(m[fpm3i_pkg::DetA[k]]) * 64'(m[fpm3i_pkg::DetB[k]]);
        c_q[k]  <= m[fpm3i_pkg::DetC[k]];
      end
      for (int k = 0; k < Lanes; k++) begin
        xa_q[k] <= 64'(m[fpm3i_pkg::AdjA[k]]) * 64'(m[fpm3i_pkg::AdjB[k]]);
        xc_q[k] <= 64'(m[fpm3i_pkg::AdjC[k]]) * 64'(m[fpm3i_pkg::AdjD[k]]);
      end
    end
  end

  // Stage 2: the 64 by 32 product modulo 2^64 is split into a low and a high half.
  always_ff @(posedge clk_i) begin
    logic signed [63:0] sh;
    logic signed [32:0] lu;
    if (en) begin
      for (int k = 0; k < Terms; k++) begin
        sh       = dp_q[k] >>> FractionBits;
        lu       = {1'b0, sh[31:0]};
        lo_q[k] <= 64'(lu) * 64'(c_q[k]);
        hi_q[k] <= sh[63:32] * c_q[k];
      end
      for (int k = 0; k < Lanes; k++) begin
        adj2_q[k] <= xa_q[k] - xc_q[k];
      end
    end
  end

  // Stage 3: recombine and drop the fraction bits again.
  always_ff @(posedge clk_i) begin
    logic signed [63:0] w;
    if (en) begin
      for (int k = 0; k < Terms; k++) begin
        w       = lo_q[k] + {hi_q[k], 32'h0};
        t_q[k] <= w >>> FractionBits;
      end
      adj3_q <= adj2_q;
    end
  end

  // Stage 4 and 5: sum the positive and negative terms, then wrap.
  always_ff @(posedge clk_i) begin
    logic signed [63:0] sum;
    if (en) begin
      pos_q  <= t_q[0] + t_q[1] + t_q[2];
      neg_q  <= t_q[3] + t_q[4] + t_q[5];
      adj4_q <= adj3_q;
      sum        = pos_q - neg_q;
      mid_q.det <= sum[31:0];
      for (int k = 0; k < Lanes; k++) begin
        mid_q.adj[k] <= adj4_q[k];
      end
    end
  end

endmodule

### hdl/fpm3i_fifo.sv
`include "fixed_point_matrix3_inverse_core_defines.svh"

module fpm3i_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  fpm3i_pkg::mid_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output fpm3i_pkg::mid_t data_o
);

  localparam int unsigned Aw = fpm3i_pkg::QueueAw;

  fpm3i_pkg::mid_t mem [fpm3i_pkg::QueueDepth];
  fpm3i_pkg::mid_t data_q;
  logic [Aw-1:0]   wr_q, rd_q;
  logic [Aw:0]     count_q;
  logic            valid_q;
  logic            push, pop, load;

  assign ready_o = count_q != (Aw+1)'(fpm3i_pkg::QueueDepth);
  assign valid_o = valid_q;
  assign push    = valid_i && ready_o;
  assign pop     = valid_q && ready_i;
  // The oldest stored beat moves to the output register whenever that register is free
  // or being drained.
  assign load    = (count_q != '0) && (!valid_q || ready_i);
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (load) begin
        rd_q <= rd_q + 1'b1;
      end
      count_q <= count_q + (Aw+1)'(push) - (Aw+1)'(load);
      if (load) begin
        valid_q <= 1'b1;
      end else if (pop) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_q] <= data_i;
    end
    if (load) begin
      data_q <= mem[rd_q];
    end
  end

  `FPM3I_ASSERT_NEVER(a_count_range, count_q > (Aw+1)'(fpm3i_pkg::QueueDepth), "queue overfilled")
  `FPM3I_ASSERT_IMPLY(a_ptr_gap, 1'b1, (wr_q - rd_q) == count_q[Aw-1:0], "queue pointers out of step")

endmodule

### hdl/fpm3i_div.sv
module fpm3i_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  fpm3i_pkg::mid_t data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output fpm3i_pkg::out_t out_data_o
);

  localparam int unsigned Lanes = fpm3i_pkg::Lanes;
  localparam int unsigned Steps = fpm3i_pkg::DivSteps;

  logic               en;
  logic [Steps:0]     v_q;
  fpm3i_pkg::div_t    st_q [Steps+1];
  fpm3i_pkg::div_t    st_d [Steps+1];
  fpm3i_pkg::div_t    fin;
  logic               out_valid_q;
  fpm3i_pkg::out_t    out_q, out_d;
  logic [31:0]        inv [Lanes];

  // One restoring step: one quotient bit per lane.
  function automatic fpm3i_pkg::div_t div_step(fpm3i_pkg::div_t cur);
    fpm3i_pkg::div_t nxt;
    logic [32:0]     t;
    logic [32:0]     d;
    logic            qb;
    nxt = cur;
    d   = {1'b0, cur.dmag};
    for (int l = 0; l < Lanes; l++) begin
      t  = {cur.rem[l], cur.dvd[l][63]};
      qb = t >= d;
      nxt.rem[l] = qb ? 32'(t - d) : t[31:0];
      nxt.dvd[l] = {cur.dvd[l][62:0], qb};
    end
    return nxt;
  endfunction

  assign en          = !out_valid_q || out_ready_i;
  assign ready_o     = en;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Stage 0 turns the signed operands into magnitudes and a sign per lane.
  always_comb begin
    st_d[0].det  = data_i.det;
    st_d[0].dmag = data_i.det[31] ? 32'(32'h0 - data_i.det) : data_i.det;
    for (int l = 0; l < Lanes; l++) begin
      st_d[0].rem[l] = '0;
      st_d[0].neg[l] = data_i.adj[l][63] ^ data_i.det[31];
      st_d[0].dvd[l] = data_i.adj[l][63] ? 64'(64'h0 - data_i.adj[l]) : data_i.adj[l];
    end
    for (int s = 1; s <= Steps; s++) begin
      st_d[s] = div_step(st_q[s-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v_q         <= {v_q[Steps-1:0], valid_i};
      out_valid_q <= v_q[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s <= Steps; s++) begin
        st_q[s] <= st_d[s];
      end
      out_q <= out_d;
    end
  end

  assign fin = st_q[Steps];

  // A zero determinant forces the whole result to zero.
  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      if (fin.det == '0) begin
        inv[l] = '0;
      end else if (fin.neg[l]) begin
        inv[l] = 32'h0 - fin.dvd[l][31:0];
      end else begin
        inv[l] = fin.dvd[l][31:0];
      end
    end
    out_d.inv_r0c0   = inv[0];
    out_d.inv_r0c1   = inv[1];
    out_d.inv_r0c2   = inv[2];
    out_d.inv_r1c0   = inv[3];
    out_d.inv_r1c1   = inv[4];
    out_d.inv_r1c2   = inv[5];
    out_d.inv_r2c0   = inv[6];
    out_d.inv_r2c1   = inv[7];
    out_d.inv_r2c2   = inv[8];
    out_d.det_value  = fin.det;
    out_d.invertible = fin.det != '0;
  end

endmodule

### hdl/fixed_point_matrix3_inverse_core.sv
// 3x3 signed fixed-point matrix inverse by the adjugate.
// Input channel: in_valid_i / in_ready_o with one whole matrix per beat in
// in_data_i. Output channel: out_valid_o / out_ready_i with the nine inverse
// elements, the wrapped determinant and the invertible flag in out_data_o.
// A zero wrapped determinant gives a clear flag and all-zero elements.
// The front pipeline forms the determinant and adjugate, a 4-beat queue with a
// registered head decouples it from the divider, which retires one quotient
// bit per stage over 64 stages for all nine elements in parallel, then an
// output register. When nothing stalls, one matrix is taken and one result is
// given every cycle.
// When the receiver stalls, the divider and output register hold, the queue
// fills, and in_ready_o drops once the front can no longer move.
// Reset clears all valid flags and queue pointers; no clearing pass is needed.
`include "fixed_point_matrix3_inverse_core_defines.svh"

module fixed_point_matrix3_inverse_core #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  fpm3i_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output fpm3i_pkg::out_t out_data_o
);

  logic            f_valid, f_ready, q_valid, q_ready;
  fpm3i_pkg::mid_t f_data, q_data;

  fpm3i_front #(
    .FractionBits(FRACTION_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .mid_valid_o (f_valid),
    .mid_ready_i (f_ready),
    .mid_data_o  (f_data)
  );

  fpm3i_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .ready_o (f_ready),
    .data_i  (f_data),
    .valid_o (q_valid),
    .ready_i (q_ready),
    .data_o  (q_data)
  );

  fpm3i_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .ready_o     (q_ready),
    .data_i      (q_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `FPM3I_ASSERT_IMPLY(a_flag_matches_det, out_valid_o, out_data_o.invertible == (out_data_o.det_value != 0), "invertible flag disagrees with determinant")
  `FPM3I_ASSERT_IMPLY(a_singular_zero, out_valid_o && !out_data_o.invertible, (out_data_o.inv_r0c0 == 0) && (out_data_o.inv_r1c1 == 0) && (out_data_o.inv_r2c2 == 0) && (out_data_o.inv_r0c1 == 0) && (out_data_o.inv_r2c0 == 0), "singular result not zero")

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned FracBits     = 16;
  localparam int unsigned Latency      = 72;
  localparam int unsigned StallLimit   = 20000;
  localparam int unsigned RandomCount  = 1900;
  localparam int          HoldCycles   = 400;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  fpm3i_pkg::in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  fpm3i_pkg::out_t out_data_o;

  fpm3i_pkg::out_t inverse_queue[$];
  int   error_count = 0;
  int   send_idle_pct = 32;
  int   recv_idle_pct = 53;
  bit   hold_off = 1'b0;
  int   hold_count = 0;
  int   hold_requests = 0;
  int   hold_served = 0;
  int   quiet_cycles = 0;

  fixed_point_matrix3_inverse_core #(
    .FRACTION_BITS(FracBits)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Sarrus product with the fraction shift after each multiply.
  function automatic logic [63:0] scaled_triple(logic signed [63:0] a, logic signed [63:0] b,
                                                logic signed [63:0] c);
    logic signed [63:0] p;
    begin
      p = a * b;
      p = p >>> FracBits;
      p = p * c;
      return p >>> FracBits;
    end
  endfunction

  function automatic fpm3i_pkg::out_t predict_inverse(fpm3i_pkg::in_t m);
    logic signed [63:0] e[9];
    logic signed [63:0] adj[9];
    logic [63:0] sum;
    logic signed [63:0] det;
    logic signed [63:0] q[9];
    fpm3i_pkg::out_t r;
    begin
      e[0] = m.in_r0c0; e[1] = m.in_r0c1; e[2] = m.in_r0c2;
      e[3] = m.in_r1c0; e[4] = m.in_r1c1; e[5] = m.in_r1c2;
      e[6] = m.in_r2c0; e[7] = m.in_r2c1; e[8] = m.in_r2c2;
      sum = scaled_triple(e[0], e[4], e[8]) + scaled_triple(e[1], e[5], e[6])
          + scaled_triple(e[2], e[3], e[7]) - scaled_triple(e[2], e[4], e[6])
          - scaled_triple(e[0], e[5], e[7]) - scaled_triple(e[1], e[3], e[8]);
      det = $signed(sum[31:0]);
      r = '0;
      if (det != 0) begin
        adj[0] = e[4] * e[8] - e[5] * e[7];
        adj[1] = e[2] * e[7] - e[1] * e[8];
        adj[2] = e[1] * e[5] - e[2] * e[4];
        adj[3] = e[5] * e[6] - e[3] * e[8];
        adj[4] = e[0] * e[8] - e[2] * e[6];
        adj[5] = e[2] * e[3] - e[0] * e[5];
        adj[6] = e[3] * e[7] - e[4] * e[6];
        adj[7] = e[1] * e[6] - e[0] * e[7];
        adj[8] = e[0] * e[4] - e[1] * e[3];
        for (int k = 0; k < 9; k++) q[k] = adj[k] / det;
        r.inv_r0c0 = q[0][31:0]; r.inv_r0c1 = q[1][31:0]; r.inv_r0c2 = q[2][31:0];
        r.inv_r1c0 = q[3][31:0]; r.inv_r1c1 = q[4][31:0]; r.inv_r1c2 = q[5][31:0];
        r.inv_r2c0 = q[6][31:0]; r.inv_r2c1 = q[7][31:0]; r.inv_r2c2 = q[8][31:0];
        r.det_value = det[31:0];
        r.invertible = 1'b1;
      end
      return r;
    end
  endfunction

  // Sends one matrix beat; valid stays high across back-to-back beats.
  task automatic send_matrix(fpm3i_pkg::in_t m);
    begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_data_i  <= m;
      inverse_queue.push_back(predict_inverse(m));
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    begin
      in_valid_i <= 1'b0;
      while (inverse_queue.size() != 0) @(posedge clk_i);
    end
  endtask

  function automatic fpm3i_pkg::in_t make_matrix(logic [31:0] a, logic [31:0] b,
                                                 logic [31:0] c, logic [31:0] d,
                                                 logic [31:0] e, logic [31:0] f,
                                                 logic [31:0] g, logic [31:0] h,
                                                 logic [31:0] i);
    fpm3i_pkg::in_t m;
    begin
      m = {a, b, c, d, e, f, g, h, i};
      return m;
    end
  endfunction

  // Fixed-point value near a fraction-scaled range, so products stay meaningful.
  function automatic logic [31:0] modest_value();
    logic [31:0] v;
    begin
      case ($urandom_range(3))
        0: v = $urandom;
        1: v = $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
        2: v = $signed($urandom_range(32'h0000_0400)) - 32'sh0000_0200;
        default: v = $signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000;
      endcase
      return v;
    end
  endfunction

  task automatic test_directed();
    localparam logic [31:0] One = 32'h0001_0000;
    localparam logic [31:0] Max = 32'h7FFF_FFFF;
    localparam logic [31:0] Min = 32'h8000_0000;
    begin
      send_matrix(make_matrix(One, 0, 0, 0, One, 0, 0, 0, One));
      send_matrix(make_matrix(2 * One, 0, 0, 0, 4 * One, 0, 0, 0, -One));
      send_matrix('0);
      // Singular: two equal rows.
      send_matrix(make_matrix(One, 2 * One, 3 * One, One, 2 * One, 3 * One, 5, 7, 9));
      send_matrix(make_matrix(Max, Max, Max, Max, Max, Max, Max, Max, Max));
      send_matrix(make_matrix(Min, Min, Min, Min, Min, Min, Min, Min, Min));
      send_matrix(make_matrix(Max, 0, 0, 0, Max, 0, 0, 0, Max));
      send_matrix(make_matrix(Min, 0, 0, 0, Min, 0, 0, 0, Min));
      send_matrix(make_matrix(Min, Max, 0, 0, Min, Max, Max, 0, Min));
      send_matrix(make_matrix(-1, 0, 0, 0, -1, 0, 0, 0, -1));
      // Small diagonal, so the scaled determinant drops to zero.
      send_matrix(make_matrix(256, 0, 0, 0, 256, 0, 0, 0, 256));
      send_matrix(make_matrix(One, One, 0, 0, One, One, One, 0, One));
      send_matrix(make_matrix(3 * One, Max, Min, 7, -One, 12345, Min, -5, Max));
      send_matrix(make_matrix(32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 1, 2, 3,
                              32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF));
      drain_results();
    end
  endtask

  task automatic test_random(int count);
    fpm3i_pkg::in_t m;
    begin
      for (int n = 0; n < count; n++) begin
        m = make_matrix(modest_value(), modest_value(), modest_value(), modest_value(),
                        modest_value(), modest_value(), modest_value(), modest_value(),
                        modest_value());
        // Some matrices get a repeated row, so they are singular.
        if ($urandom_range(9) == 0) begin
          m.in_r2c0 = m.in_r0c0; m.in_r2c1 = m.in_r0c1; m.in_r2c2 = m.in_r0c2;
        end
        send_matrix(m);
      end
    end
  endtask

  task automatic test_backpressure();
    begin
      hold_requests++;
      test_random(120);
      drain_results();
    end
  endtask

  // Receiver: random stalls, plus one long hold-off counted here.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_off) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (hold_off) begin
      if (hold_count == HoldCycles - 1) begin
        hold_off   <= 1'b0;
        hold_count <= 0;
      end else begin
        hold_count <= hold_count + 1;
      end
    end else if (hold_served != hold_requests) begin
      hold_off    <= 1'b1;
      hold_served <= hold_served + 1;
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    fpm3i_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (inverse_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data_o);
        error_count++;
      end else begin
        want = inverse_queue.pop_front();
        if (want.inv_r0c0 !== out_data_o.inv_r0c0 || want.inv_r0c1 !== out_data_o.inv_r0c1
            || want.inv_r0c2 !== out_data_o.inv_r0c2 || want.inv_r1c0 !== out_data_o.inv_r1c0
            || want.inv_r1c1 !== out_data_o.inv_r1c1 || want.inv_r1c2 !== out_data_o.inv_r1c2
            || want.inv_r2c0 !== out_data_o.inv_r2c0 || want.inv_r2c1 !== out_data_o.inv_r2c1
            || want.inv_r2c2 !== out_data_o.inv_r2c2
            || want.det_value !== out_data_o.det_value
            || want.invertible !== out_data_o.invertible) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, out_data_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("FAIL fixed_point_matrix3_inverse_core");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure();
    test_random(RandomCount / 3);
    drain_results();
    send_idle_pct = 53;
    recv_idle_pct = 32;
    test_random(RandomCount / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(RandomCount / 3);
    drain_results();
    repeat (Latency + 10) @(posedge clk_i);

    if (error_count == 0 && inverse_queue.size() == 0) begin
      $display("PASS fixed_point_matrix3_inverse_core");
    end else begin
      $display("FAIL fixed_point_matrix3_inverse_core");
    end
    $finish;
  end

endmodule
